### rtl/core/dfs_parity_team_split_top_defines.svh
// ----------------------------------------------------------------------------
// dfs_parity_team_split_top_defines.svh
// Assertion macros shared by the block's modules.
// ----------------------------------------------------------------------------
`ifndef DFS_PARITY_TEAM_SPLIT_TOP_DEFINES_SVH
`define DFS_PARITY_TEAM_SPLIT_TOP_DEFINES_SVH

// check a property on every clock edge outside reset
`define DFSP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// check that a condition holds in the cycle after a trigger
`define DFSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/dfsp_pkg.sv
// ----------------------------------------------------------------------------
// dfsp_pkg
// Field widths, command codes and result types of the parity walk block.
// ----------------------------------------------------------------------------
package dfsp_pkg;

   localparam int CMD_W  = 2;
   localparam int VTX_W  = 6;
   localparam int CNT_W  = 7;
   localparam int MASK_W = 64;

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic              failed;
      logic [CNT_W-1:0]  team_count;
      logic [MASK_W-1:0] team_mask;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } rsp_load_type;

endpackage

### rtl/core/dfsp_req_if.sv
// ----------------------------------------------------------------------------
// dfsp_req_if
// Request channel: command word with vertex and neighbor fields.
// ----------------------------------------------------------------------------
interface dfsp_req_if;
   logic                       valid;
   logic                       ready;
   logic [dfsp_pkg::CMD_W-1:0] command;
   logic [dfsp_pkg::VTX_W-1:0] vertex;
   logic [dfsp_pkg::VTX_W-1:0] neighbor;

   modport source (output valid, command, vertex, neighbor, input ready);
   modport sink (input valid, command, vertex, neighbor, output ready);
endinterface

### rtl/core/dfsp_rsp_if.sv
// ----------------------------------------------------------------------------
// dfsp_rsp_if
// Response channel: failure flag, odd-depth count and odd-depth mask.
// ----------------------------------------------------------------------------
interface dfsp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        failed;
   logic [dfsp_pkg::CNT_W-1:0]  team_count;
   logic [dfsp_pkg::MASK_W-1:0] team_mask;

   modport source (output valid, failed, team_count, team_mask, input ready);
   modport sink (input valid, failed, team_count, team_mask, output ready);
endinterface

### rtl/core/dfsp_csr_if.sv
// ----------------------------------------------------------------------------
// dfsp_csr_if
// Register write channel carrying the vertex count.
// ----------------------------------------------------------------------------
interface dfsp_csr_if;
   logic                       valid;
   logic                       ready;
   logic [dfsp_pkg::CNT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

### rtl/core/dfsp_ram.sv
// ----------------------------------------------------------------------------
// dfsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/dfsp_ctrl.sv
// ----------------------------------------------------------------------------
// dfsp_ctrl
// List loader and depth-first walk sequencer over the list, length and
// stack memories.
// ----------------------------------------------------------------------------
`include "dfs_parity_team_split_top_defines.svh"

module dfsp_ctrl #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_DEGREE   = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   dfsp_req_if.sink                   req,
   input  logic [dfsp_pkg::CNT_W-1:0] active_count,
   input  logic                       out_free,
   output dfsp_pkg::rsp_load_type     out_load
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int DPW = VW + 1;
   localparam int LW  = $clog2(MAX_DEGREE + 1);
   localparam int ND  = MAX_VERTICES * MAX_DEGREE;
   localparam int AW  = $clog2(ND);
   localparam int FW  = VW + 2 * LW;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ADD    = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_ENTER  = 3'd3;
   localparam logic [2:0] S_STEP   = 3'd4;
   localparam logic [2:0] S_POP    = 3'd5;
   localparam logic [2:0] S_NBR    = 3'd6;
   localparam logic [2:0] S_REPORT = 3'd7;

   logic [2:0]                 state_ff, state_in;
   logic [MAX_VERTICES-1:0]    lvalid_ff, lvalid_in;
   logic [MAX_VERTICES-1:0]    visited_ff, visited_in;
   logic [MAX_VERTICES-1:0]    parity_ff, parity_in;
   logic                       fail_ff, fail_in;
   logic [dfsp_pkg::CNT_W-1:0] count_ff, count_in;
   logic [DPW-1:0]             depth_ff, depth_in;
   logic [dfsp_pkg::CNT_W-1:0] scan_ff, scan_in;
   logic [VW-1:0]              pv_ff, pv_in;
   logic [VW-1:0]              add_nbr_ff, add_nbr_in;
   logic [VW-1:0]              top_v_ff, top_v_in;
   logic [LW-1:0]              top_k_ff, top_k_in;
   logic [LW-1:0]              top_len_ff, top_len_in;

   logic          len_we;
   logic [VW-1:0] len_waddr;
   logic [LW-1:0] len_wdata;
   logic [VW-1:0] len_raddr;
   logic [LW-1:0] len_rd;
   logic [LW-1:0] len_cur;

   logic          nbr_we;
   logic [AW-1:0] nbr_waddr;
   logic [AW-1:0] nbr_raddr;
   logic [VW-1:0] nbr_rd;

   logic          stk_we;
   logic [VW-1:0] stk_waddr;
   logic [FW-1:0] stk_wdata;
   logic [VW-1:0] stk_raddr;
   logic [FW-1:0] stk_rd;

   logic in_range;
   logic nbr_skip;

   function automatic logic [AW-1:0] list_addr(input logic [VW-1:0] v,
                                                input logic [LW-1:0] k);
      list_addr = AW'(v) * AW'(MAX_DEGREE) + AW'(k);
   endfunction

   dfsp_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (len_waddr),
      .wr_data (len_wdata),
      .rd_addr (len_raddr),
      .rd_data (len_rd)
   );

   dfsp_ram #(.WIDTH(VW), .DEPTH(ND)) u_list_ram (
      .clock   (clock),
      .wr_en   (nbr_we),
      .wr_addr (nbr_waddr),
      .wr_data (add_nbr_ff),
      .rd_addr (nbr_raddr),
      .rd_data (nbr_rd)
   );

   dfsp_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rd)
   );

   assign req.ready = (state_ff == S_IDLE);

   assign len_cur  = lvalid_ff[pv_ff] ? len_rd : '0;
   assign in_range = ({1'b0, req.vertex} < active_count) &&
                     ({1'b0, req.neighbor} < active_count);
   assign nbr_skip = ({1'b0, nbr_rd} >= DPW'(MAX_VERTICES)) || visited_ff[nbr_rd];

   always_comb begin
      case (state_ff)
         S_IDLE:  len_raddr = req.vertex[VW-1:0];
         S_SCAN:  len_raddr = scan_ff[VW-1:0];
         default: len_raddr = nbr_rd;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      lvalid_in  = lvalid_ff;
      visited_in = visited_ff;
      parity_in  = parity_ff;
      fail_in    = fail_ff;
      count_in   = count_ff;
      depth_in   = depth_ff;
      scan_in    = scan_ff;
      pv_in      = pv_ff;
      add_nbr_in = add_nbr_ff;
      top_v_in   = top_v_ff;
      top_k_in   = top_k_ff;
      top_len_in = top_len_ff;
      len_we     = 1'b0;
      len_waddr  = pv_ff;
      len_wdata  = len_cur + LW'(1);
      nbr_we     = 1'b0;
      nbr_waddr  = list_addr(pv_ff, len_cur);
      nbr_raddr  = list_addr(top_v_ff, top_k_ff);
      stk_we     = 1'b0;
      stk_waddr  = VW'(depth_ff - DPW'(1));
      stk_wdata  = {top_v_ff, top_k_ff, top_len_ff};
      stk_raddr  = VW'(depth_ff - DPW'(2));
      out_load   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               case (req.command)
                  dfsp_pkg::CMD_ADD: begin
                     if (in_range) begin
                        pv_in      = req.vertex[VW-1:0];
                        add_nbr_in = req.neighbor[VW-1:0];
                        state_in   = S_ADD;
                     end
                  end
                  dfsp_pkg::CMD_RUN: begin
                     visited_in = '0;
                     parity_in  = '0;
                     fail_in    = 1'b0;
                     count_in   = '0;
                     depth_in   = '0;
                     scan_in    = '0;
                     state_in   = S_SCAN;
                  end
                  dfsp_pkg::CMD_CLEAR: begin
                     lvalid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ADD: begin
            if (len_cur < LW'(MAX_DEGREE)) begin
               nbr_we           = 1'b1;
               len_we           = 1'b1;
               lvalid_in[pv_ff] = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_SCAN: begin
            if (scan_ff >= active_count) begin
               state_in = S_REPORT;
            end else begin
               scan_in = scan_ff + dfsp_pkg::CNT_W'(1);
               if (!visited_ff[scan_ff[VW-1:0]]) begin
                  pv_in    = scan_ff[VW-1:0];
                  state_in = S_ENTER;
               end
            end
         end
         S_ENTER: begin
            if (len_cur == '0) begin
               fail_in  = 1'b1;
               state_in = (depth_ff == '0) ? S_SCAN : S_STEP;
            end else if (depth_ff == DPW'(MAX_VERTICES)) begin
               state_in = S_STEP;
            end else begin
               stk_we            = (depth_ff != '0);
               top_v_in          = pv_ff;
               top_k_in          = '0;
               top_len_in        = len_cur;
               visited_in[pv_ff] = 1'b1;
               if (depth_ff[0]) begin
                  parity_in[pv_ff] = 1'b1;
                  count_in         = count_ff + dfsp_pkg::CNT_W'(1);
               end
               depth_in = depth_ff + DPW'(1);
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (top_k_ff >= top_len_ff) begin
               depth_in = depth_ff - DPW'(1);
               state_in = (depth_ff == DPW'(1)) ? S_SCAN : S_POP;
            end else begin
               top_k_in = top_k_ff + LW'(1);
               state_in = S_NBR;
            end
         end
         S_POP: begin
            {top_v_in, top_k_in, top_len_in} = stk_rd;
            state_in = S_STEP;
         end
         S_NBR: begin
            if (nbr_skip) begin
               state_in = S_STEP;
            end else begin
               pv_in    = nbr_rd;
               state_in = S_ENTER;
            end
         end
         S_REPORT: begin
            if (out_free) begin
               out_load.valid             = 1'b1;
               out_load.result.failed     = fail_ff;
               out_load.result.team_count = fail_ff ? '0 : count_ff;
               out_load.result.team_mask  = fail_ff ? '0 : dfsp_pkg::MASK_W'(parity_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         lvalid_ff  <= '0;
         visited_ff <= '0;
         parity_ff  <= '0;
         fail_ff    <= 1'b0;
         count_ff   <= '0;
         depth_ff   <= '0;
         scan_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         lvalid_ff  <= lvalid_in;
         visited_ff <= visited_in;
         parity_ff  <= parity_in;
         fail_ff    <= fail_in;
         count_ff   <= count_in;
         depth_ff   <= depth_in;
         scan_ff    <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      pv_ff      <= pv_in;
      add_nbr_ff <= add_nbr_in;
      top_v_ff   <= top_v_in;
      top_k_ff   <= top_k_in;
      top_len_ff <= top_len_in;
   end

   `DFSP_ASSERT(a_depth_bound, depth_ff <= DPW'(MAX_VERTICES), "walk stack overflow")
   `DFSP_ASSERT(a_step_frame, (state_ff == S_STEP) |-> (depth_ff != '0), "step with empty stack")
   `DFSP_ASSERT(a_count_match, count_ff == dfsp_pkg::CNT_W'($countones(parity_ff)), "odd count off")
   `DFSP_ASSERT(a_odd_visited, (parity_ff & ~visited_ff) == '0, "odd mark on unvisited vertex")
   `DFSP_ASSERT_NEXT(a_run_start, req.valid && req.ready && (req.command == dfsp_pkg::CMD_RUN), (state_ff == S_SCAN) && (visited_ff == '0), "run did not start clean")

endmodule

### rtl/core/dfsp_rsp_reg.sv
// ----------------------------------------------------------------------------
// dfsp_rsp_reg
// Output register for the result word; frees the walker while it waits.
// ----------------------------------------------------------------------------
`include "dfs_parity_team_split_top_defines.svh"

module dfsp_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  dfsp_pkg::rsp_load_type ld,
   output logic                   free,
   dfsp_rsp_if.source             rsp
);

   logic                 valid_ff, valid_in;
   dfsp_pkg::result_type data_ff, data_in;

   assign free = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ld.valid) begin
         valid_in = 1'b1;
         data_in  = ld.result;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp.valid      = valid_ff;
   assign rsp.failed     = data_ff.failed;
   assign rsp.team_count = data_ff.team_count;
   assign rsp.team_mask  = data_ff.team_mask;

   `DFSP_ASSERT(a_load_free, ld.valid |-> (!valid_ff || rsp.ready), "result overwritten")

endmodule

### rtl/core/dfs_parity_team_split_top.sv
// ----------------------------------------------------------------------------
// dfs_parity_team_split_top
// Depth-parity two-coloring of a loaded graph by depth-first walk.
//
// req_chan takes one word at a time: add appends a neighbor to a vertex's
// list, clear empties all lists, run walks the graph and reports.
// rsp_chan carries one word per run: failed, team_count and team_mask.
// csr_chan writes vertex_count and is always ready; vertex_count must be
// written only while idle, which the block does not enforce. An add in range
// reads the list length, then writes the list and length; a dropped add, clear
// and an unknown command finish in idle. A run starts, checks each start
// vertex, takes a step and a neighbor read per list entry, enters each new
// vertex, leaves each vertex with a stack read when a parent frame resumes,
// ends the scan and reports; this walk limits throughput, one item at a time.
// The result sits in an output register; a new word is taken while it waits.
// A stalled receiver holds the result; a following run waits at report.
// Reset empties all lists at once, sets vertex_count to 1 and drops any
// pending result.
// ----------------------------------------------------------------------------
module dfs_parity_team_split_top #(
   parameter int MAX_VERTICES = 64,
   parameter int MAX_DEGREE   = 64
) (
   input logic        clock,
   input logic        reset,
   dfsp_req_if.sink   req_chan,
   dfsp_rsp_if.source rsp_chan,
   dfsp_csr_if.sink   csr_chan
);

   logic [dfsp_pkg::CNT_W-1:0] vertex_count_ff, vertex_count_in;
   logic [dfsp_pkg::CNT_W-1:0] active_count;
   dfsp_pkg::rsp_load_type     out_load;
   logic                       out_free;

   assign csr_chan.ready  = 1'b1;
   assign vertex_count_in = csr_chan.valid ? csr_chan.data : vertex_count_ff;
   assign active_count    = (vertex_count_ff > dfsp_pkg::CNT_W'(MAX_VERTICES)) ?
                            dfsp_pkg::CNT_W'(MAX_VERTICES) : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= dfsp_pkg::CNT_W'(1);
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   dfsp_ctrl #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_DEGREE   (MAX_DEGREE)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .active_count (active_count),
      .out_free     (out_free),
      .out_load     (out_load)
   );

   dfsp_rsp_reg u_rsp_reg (
      .clock (clock),
      .reset (reset),
      .ld    (out_load),
      .free  (out_free),
      .rsp   (rsp_chan)
   );

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the depth-parity team split block. A short scripted table covers
// reset state, dropped entries, the ignored command, a count of zero, a count
// above the vertex limit, a lowered count and failing walks. Random graphs,
// chains, broken graphs, full lists and noise follow, under several vertex
// counts. Run words without a scripted result are predicted by a local
// depth-first walk; each response word is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int MAX_V         = 64;
   localparam int MAX_D         = 64;
   localparam int DIRECTED_ROWS = 25;
   localparam int WORD_TARGET   = 430;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 40000;

   localparam logic [dfsp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam dfsp_pkg::result_type RES_EMPTY  = '{1'b0, '0, '0};
   localparam dfsp_pkg::result_type RES_FAILED = '{1'b1, '0, '0};

   typedef enum logic {ROW_WORD, ROW_CONFIG} row_kind_type;
   typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_type;
   typedef enum logic [2:0] {
      SEQ_NOISE, SEQ_BROKEN, SEQ_FILL, SEQ_PRESSURE, SEQ_PAUSE, SEQ_CHAIN, SEQ_GRAPH
   } seq_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic [dfsp_pkg::CMD_W-1:0] cmd;
      logic [dfsp_pkg::VTX_W-1:0] vtx;
      logic [dfsp_pkg::VTX_W-1:0] nbr;
      logic [dfsp_pkg::CNT_W-1:0] cnt;
      bit                         typed;
      dfsp_pkg::result_type       res;
   } script_row_type;

   logic clock;
   logic reset;

   dfsp_req_if req_bus ();
   dfsp_rsp_if rsp_bus ();
   dfsp_csr_if csr_bus ();

   dfs_parity_team_split_top #(
      .MAX_VERTICES (MAX_V),
      .MAX_DEGREE   (MAX_D)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   logic [dfsp_pkg::VTX_W-1:0] graph_entry [MAX_V][MAX_D];
   logic [dfsp_pkg::CNT_W-1:0] graph_len [MAX_V];
   logic [dfsp_pkg::CNT_W-1:0] vertex_limit;
   dfsp_pkg::result_type       team_results_q [$];

   int  mismatch_count = 0;
   int  quiet_cycles   = 0;
   int  words_sent     = 0;
   int  burst_left     = 0;
   bit  hold_request   = 1'b0;

   script_row_type directed_script [DIRECTED_ROWS] = '{
      '{ROW_WORD,   dfsp_pkg::CMD_RUN,   6'd0,  6'd0,  7'd0,   1'b1, RES_FAILED},
      '{ROW_WORD,   dfsp_pkg::CMD_ADD,   6'd0,  6'd0,  7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_RUN,   6'd0,  6'd0,  7'd0,   1'b1, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_ADD,   6'd0,  6'd1,  7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_ADD,   6'd1,  6'd0,  7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   CMD_UNUSED,          6'd63, 6'd63, 7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_RUN,   6'd63, 6'd63, 7'd0,   1'b1, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_CLEAR, 6'd63, 6'd0,  7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_RUN,   6'd0,  6'd0,  7'd0,   1'b1, RES_FAILED},
      '{ROW_CONFIG, dfsp_pkg::CMD_ADD,   6'd0,  6'd0,  7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_ADD,   6'd0,  6'd0,  7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_RUN,   6'd0,  6'd0,  7'd0,   1'b1, RES_EMPTY},
      '{ROW_CONFIG, dfsp_pkg::CMD_ADD,   6'd0,  6'd0,  7'd127, 1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_ADD,   6'd63, 6'd0,  7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_ADD,   6'd0,  6'd63, 7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_ADD,   6'd63, 6'd63, 7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_RUN,   6'd0,  6'd0,  7'd0,   1'b1, RES_FAILED},
      '{ROW_CONFIG, dfsp_pkg::CMD_ADD,   6'd0,  6'd0,  7'd2,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_ADD,   6'd1,  6'd0,  7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_ADD,   6'd0,  6'd1,  7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_RUN,   6'd0,  6'd0,  7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_CLEAR, 6'd0,  6'd0,  7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_ADD,   6'd0,  6'd1,  7'd0,   1'b0, RES_EMPTY},
      '{ROW_WORD,   dfsp_pkg::CMD_RUN,   6'd0,  6'd0,  7'd0,   1'b1, RES_FAILED},
      '{ROW_CONFIG, dfsp_pkg::CMD_ADD,   6'd0,  6'd0,  7'd64,  1'b0, RES_EMPTY}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int effective_vertices();
      return (vertex_limit > MAX_V) ? MAX_V : int'(vertex_limit);
   endfunction

   function automatic dfsp_pkg::result_type predict_team_split();
      logic [dfsp_pkg::MASK_W-1:0] seen;
      logic [dfsp_pkg::MASK_W-1:0] odd;
      logic [dfsp_pkg::VTX_W-1:0]  frame_vtx [MAX_V];
      int                          frame_idx [MAX_V];
      logic [dfsp_pkg::VTX_W-1:0]  pending;
      bit                          has_pending;
      bit                          broken;
      int                          depth;
      int                          n;
      int                          k;
      logic [dfsp_pkg::VTX_W-1:0]  v;
      n = effective_vertices();
      seen = '0;
      odd = '0;
      broken = 1'b0;
      for (int s = 0; s < n; s++) begin
         if (!seen[s]) begin
            depth = 0;
            pending = dfsp_pkg::VTX_W'(s);
            has_pending = 1'b1;
            while (has_pending || depth > 0) begin
               if (has_pending) begin
                  has_pending = 1'b0;
                  if (graph_len[pending] == 0) begin
                     broken = 1'b1;
                  end else if (depth < MAX_V) begin
                     seen[pending] = 1'b1;
                     if (depth % 2 == 1) odd[pending] = 1'b1;
                     frame_vtx[depth] = pending;
                     frame_idx[depth] = 0;
                     depth++;
                  end
               end else begin
                  v = frame_vtx[depth-1];
                  k = frame_idx[depth-1];
                  if (k >= graph_len[v]) begin
                     depth--;
                  end else begin
                     frame_idx[depth-1] = k + 1;
                     if (!seen[graph_entry[v][k]]) begin
                        pending = graph_entry[v][k];
                        has_pending = 1'b1;
                     end
                  end
               end
            end
         end
      end
      if (broken) return RES_FAILED;
      return '{1'b0, dfsp_pkg::CNT_W'($countones(odd)), odd};
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 100)
         $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $time);
      mismatch_count++;
   endtask

   task automatic send_word(input logic [dfsp_pkg::CMD_W-1:0] cmd,
                            input logic [dfsp_pkg::VTX_W-1:0] vtx,
                            input logic [dfsp_pkg::VTX_W-1:0] nbr,
                            input bit typed = 1'b0,
                            input dfsp_pkg::result_type typed_res = RES_EMPTY);
      int n;
      if (burst_left == 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      @(negedge clock);
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.vertex   <= vtx;
      req_bus.neighbor <= nbr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      n = effective_vertices();
      if (cmd != CMD_UNUSED) words_sent++;
      case (cmd)
         dfsp_pkg::CMD_ADD: begin
            if (vtx < n && nbr < n && graph_len[vtx] < MAX_D) begin
               graph_entry[vtx][graph_len[vtx]] = nbr;
               graph_len[vtx]++;
            end
         end
         dfsp_pkg::CMD_CLEAR: foreach (graph_len[i]) graph_len[i] = '0;
         dfsp_pkg::CMD_RUN: begin
            team_results_q = {team_results_q, typed ? typed_res : predict_team_split()};
         end
         default: ;
      endcase
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (team_results_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [dfsp_pkg::CNT_W-1:0] cnt);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= cnt;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      vertex_limit = cnt;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin : rsp_pacer
      rx_mode_type mode;
      int          mode_left;
      int          sparse_phase;
      rsp_bus.ready = 1'b0;
      mode = RX_OPEN;
      mode_left = 0;
      sparse_phase = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            sparse_phase++;
            case (mode)
               RX_OPEN:   rsp_bus.ready <= 1'b1;
               RX_RANDOM: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default:   rsp_bus.ready <= (sparse_phase % 3 == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_results
      dfsp_pkg::result_type want;
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (team_results_q.size() == 0) begin
            report_mismatch("unexpected word", {rsp_bus.team_mask}, '0);
         end else begin
            want = team_results_q.pop_front();
            if (rsp_bus.failed !== want.failed)
               report_mismatch("failed", 64'(rsp_bus.failed), 64'(want.failed));
            if (rsp_bus.team_count !== want.team_count)
               report_mismatch("team_count", 64'(rsp_bus.team_count),
                               64'(want.team_count));
            if (rsp_bus.team_mask !== want.team_mask)
               report_mismatch("team_mask", rsp_bus.team_mask, want.team_mask);
         end
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      logic [dfsp_pkg::CNT_W-1:0] count_sel;
      seq_kind_type               kind;
      bit                         pressure_done;
      int                         n_eff;
      int                         skip;
      int                         pick;
      int                         hot;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.command  = dfsp_pkg::CMD_ADD;
      req_bus.vertex   = '0;
      req_bus.neighbor = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.data     = '0;
      vertex_limit     = 7'd1;
      pressure_done    = 1'b0;
      foreach (graph_len[i]) graph_len[i] = '0;
      foreach (graph_entry[i, j]) graph_entry[i][j] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_script[i]) begin
         if (directed_script[i].kind == ROW_CONFIG)
            write_vertex_count(directed_script[i].cnt);
         else
            send_word(directed_script[i].cmd, directed_script[i].vtx, directed_script[i].nbr,
                      directed_script[i].typed, directed_script[i].res);
      end

      while (words_sent < WORD_TARGET) begin
         pick = $urandom_range(0, 15);
         case (pick)
            0:       count_sel = 7'd64;
            1:       count_sel = 7'd127;
            2:       count_sel = 7'd0;
            3:       count_sel = dfsp_pkg::CNT_W'($urandom_range(9, 32));
            default: count_sel = dfsp_pkg::CNT_W'($urandom_range(1, 8));
         endcase
         write_vertex_count(count_sel);
         n_eff = effective_vertices();
         repeat ($urandom_range(2, 5)) begin
            if (words_sent >= WORD_TARGET) break;
            pick = $urandom_range(0, 13);
            if (pick >= 10)     kind = SEQ_GRAPH;
            else if (pick >= 7) kind = SEQ_CHAIN;
            else                kind = seq_kind_type'(pick);
            if (!pressure_done) kind = SEQ_PRESSURE;
            case (kind)
               SEQ_NOISE: begin
                  repeat ($urandom_range(1, 8))
                     send_word(dfsp_pkg::CMD_W'($urandom_range(0, 3)),
                               dfsp_pkg::VTX_W'($urandom_range(0, 63)),
                               dfsp_pkg::VTX_W'($urandom_range(0, 63)));
               end
               SEQ_FILL: begin
                  if (n_eff > 0) begin
                     hot = $urandom_range(0, n_eff - 1);
                     repeat (MAX_D + 2)
                        send_word(dfsp_pkg::CMD_ADD, dfsp_pkg::VTX_W'(hot),
                                  dfsp_pkg::VTX_W'($urandom_range(0, n_eff - 1)));
                     send_word(dfsp_pkg::CMD_RUN, dfsp_pkg::VTX_W'($urandom_range(0, 63)),
                               '0);
                  end
               end
               SEQ_PRESSURE: begin
                  pressure_done = 1'b1;
                  hold_request = 1'b1;
                  send_word(dfsp_pkg::CMD_RUN, '0, '0);
                  send_word(dfsp_pkg::CMD_ADD, '0, dfsp_pkg::VTX_W'($urandom_range(0, 63)));
                  repeat (3) send_word(dfsp_pkg::CMD_RUN, '0, '0);
               end
               SEQ_PAUSE: drain_results();
               default: begin
                  if ($urandom_range(0, 4) != 0)
                     send_word(dfsp_pkg::CMD_CLEAR, dfsp_pkg::VTX_W'($urandom_range(0, 63)),
                               dfsp_pkg::VTX_W'($urandom_range(0, 63)));
                  skip = (kind == SEQ_BROKEN && n_eff > 0) ? $urandom_range(0, n_eff - 1) : -1;
                  for (int v = 0; v < n_eff; v++) begin
                     if (v != skip) begin
                        if (kind == SEQ_CHAIN)
                           send_word(dfsp_pkg::CMD_ADD, dfsp_pkg::VTX_W'(v),
                                     dfsp_pkg::VTX_W'((v + 1) % n_eff));
                        repeat ($urandom_range(kind == SEQ_CHAIN ? 0 : 1, 3))
                           send_word(dfsp_pkg::CMD_ADD, dfsp_pkg::VTX_W'(v),
                                     ($urandom_range(0, 15) == 0)
                                        ? dfsp_pkg::VTX_W'($urandom_range(0, 63))
                                        : dfsp_pkg::VTX_W'($urandom_range(0, n_eff - 1)));
                     end
                  end
                  send_word(dfsp_pkg::CMD_RUN, dfsp_pkg::VTX_W'($urandom_range(0, 63)),
                            dfsp_pkg::VTX_W'($urandom_range(0, 63)));
               end
            endcase
         end
      end

      drain_results();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
